// ----- hdl/l2ep_pkg.sv -----
// Shared types and constants for the layer-2 encapsulation parser.
// No dependencies; imported by every module of the block.
package l2ep_pkg;

  localparam int MPLS_MAX = 10;
  localparam int LBL_CW   = $clog2(MPLS_MAX + 1);
  localparam int LBL_IW   = (MPLS_MAX > 1) ? $clog2(MPLS_MAX) : 1;

  localparam logic [15:0] ET_MAX_LEN = 16'd1500;
  localparam logic [15:0] ET_IPV4    = 16'h0800;
  localparam logic [15:0] ET_IPV6    = 16'h86DD;
  localparam logic [15:0] ET_VLAN    = 16'h8100;
  localparam logic [15:0] ET_QINQ    = 16'h88A8;
  localparam logic [15:0] ET_MPLS    = 16'h8847;
  localparam logic [15:0] ET_TEB     = 16'h6558;
  localparam logic [15:0] ET_PPPOE   = 16'h8864;
  localparam logic [15:0] PPP_IPV4   = 16'h0021;
  localparam logic [15:0] PPP_IPV6   = 16'h0057;
  localparam logic [7:0]  PPPOE_VER_TYPE = 8'h11;
  localparam logic [7:0]  PPPOE_CODE_SESSION = 8'h00;
  localparam int          MPLS_BOS_BIT = 8;
  localparam logic [3:0]  NIB_IPV4 = 4'h4;
  localparam logic [3:0]  NIB_IPV6 = 4'h6;

  // byte positions (count after the byte is shifted in)
  localparam logic [3:0] VLAN_HDR_LEN  = 4'd4;
  localparam logic [3:0] MPLS_LBL_LEN  = 4'd4;
  localparam logic [3:0] GRE_DST_END   = 4'd6;
  localparam logic [3:0] GRE_SRC_END   = 4'd12;
  localparam logic [3:0] GRE_HDR_LEN   = 4'd14;
  localparam logic [3:0] PPPOE_VC_END  = 4'd2;
  localparam logic [3:0] PPPOE_HDR_LEN = 4'd8;

  localparam logic [9:0] HDR_BYTES_MAX = 10'd1023;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_VLAN, PH_MPLS, PH_PEEK, PH_GRE, PH_PPPOE
  } phase_t;

  typedef enum logic [1:0] {
    VERD_IP      = 2'd0,
    VERD_UNKNOWN = 2'd1,
    VERD_LEN_ERR = 2'd2
  } verdict_t;

  // summary of a finished parse, handed to the result side
  typedef struct packed {
    verdict_t          verdict;
    logic [15:0]       next_protocol;
    logic [11:0]       vlan_id;
    logic [LBL_CW-1:0] label_count;
    logic [47:0]       dst_mac;
    logic [47:0]       src_mac;
    logic              tunnel_seen;
    logic [9:0]        header_bytes;
  } run_info_t;

endpackage

// ----- hdl/l2_encapsulation_parser_top.sv -----
// Top level of the layer-2 encapsulation parser.
// Depends on l2ep_pkg, l2ep_parser and l2ep_emitter.
//
// Takes one packet item per cycle (first item carries the starting ethertype, every item
// may carry one header byte) and walks VLAN, MPLS, GRE transparent-ethernet and PPPoE
// session headers until a verdict: IP reached, unknown/unsupported, or length error.
// Each item goes through an input register and combinational parse logic; a verdict is then
// loaded into the result register when the parser advances on that item. A verdict
// produces a run of 1 + mpls_count result transactions (verdict first, then the stored
// labels in wire order, last_result on the final one). While a run is being delivered the
// parser holds its next item until the final result of the run is taken, so input
// throughput is one item per cycle except that a run with labels stalls the input until its
// label results are taken, and the input also waits while the result side stalls.
// Items after a verdict are absorbed without results until the next first item.
// No clearing pass after reset.
module l2_encapsulation_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first,
  input  logic [15:0] start_ethertype,
  input  logic        byte_valid,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [15:0] next_protocol,
  output logic [11:0] vlan_id,
  output logic [3:0]  mpls_count,
  output logic [31:0] mpls_label,
  output logic [47:0] dst_mac,
  output logic [47:0] src_mac,
  output logic        tunnel_seen,
  output logic [9:0]  header_bytes,
  output logic        last_result
);
  import l2ep_pkg::*;

  logic              load_ready;
  logic              run_load;
  run_info_t         run_info;
  logic [LBL_IW-1:0] lbl_rd_idx;
  logic [31:0]       lbl_rd_data;

  l2ep_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .first           (first),
    .start_ethertype (start_ethertype),
    .byte_valid      (byte_valid),
    .data_byte       (data_byte),
    .last            (last),
    .load_ready      (load_ready),
    .run_load        (run_load),
    .run_info        (run_info),
    .lbl_rd_idx      (lbl_rd_idx),
    .lbl_rd_data     (lbl_rd_data)
  );

  l2ep_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .run_load      (run_load),
    .run_info      (run_info),
    .load_ready    (load_ready),
    .lbl_rd_idx    (lbl_rd_idx),
    .lbl_rd_data   (lbl_rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .next_protocol (next_protocol),
    .vlan_id       (vlan_id),
    .mpls_count    (mpls_count),
    .mpls_label    (mpls_label),
    .dst_mac       (dst_mac),
    .src_mac       (src_mac),
    .tunnel_seen   (tunnel_seen),
    .header_bytes  (header_bytes),
    .last_result   (last_result)
  );

endmodule

// ----- hdl/l2ep_parser.sv -----
// Input register, per-packet parse state and MPLS label store.
// Depends on l2ep_pkg; feeds l2ep_emitter.
module l2ep_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        first,
  input  logic [15:0]                 start_ethertype,
  input  logic                        byte_valid,
  input  logic [7:0]                  data_byte,
  input  logic                        last,
  input  logic                        load_ready,
  output logic                        run_load,
  output l2ep_pkg::run_info_t         run_info,
  input  logic [l2ep_pkg::LBL_IW-1:0] lbl_rd_idx,
  output logic [31:0]                 lbl_rd_data
);
  import l2ep_pkg::*;

  typedef struct packed {
    logic     done;
    verdict_t verdict;
    phase_t   phase;
  } eval_t;

  function automatic eval_t evaluate(input logic [15:0] t);
    eval_t e;
    e.done    = 1'b1;
    e.verdict = VERD_UNKNOWN;
    e.phase   = PH_IDLE;
    if (t <= ET_MAX_LEN) begin
      e.verdict = VERD_UNKNOWN;
    end else if (t == ET_IPV4 || t == ET_IPV6) begin
      e.verdict = VERD_IP;
    end else if (t == ET_VLAN || t == ET_QINQ) begin
      e.done  = 1'b0;
      e.phase = PH_VLAN;
    end else if (t == ET_MPLS) begin
      e.done  = 1'b0;
      e.phase = PH_MPLS;
    end else if (t == ET_TEB) begin
      e.done  = 1'b0;
      e.phase = PH_GRE;
    end else if (t == ET_PPPOE) begin
      e.done  = 1'b0;
      e.phase = PH_PPPOE;
    end
    return e;
  endfunction

  // input register
  logic        in_q_valid;
  logic        q_first;
  logic [15:0] q_type;
  logic        q_byte_valid;
  logic [7:0]  q_byte;
  logic        q_last;
  logic        advance;

  // parse state
  phase_t            phase, phase_next;
  logic [15:0]       cur_type, cur_type_next;
  logic [3:0]        idx, idx_next;
  logic [47:0]       shift_word, shift_word_next;
  logic [15:0]       pppoe_vc, pppoe_vc_next;
  logic [11:0]       vlan, vlan_next;
  logic [LBL_CW-1:0] lbl_cnt, lbl_cnt_next;
  logic [47:0]       dst_mac, dst_mac_next;
  logic [47:0]       src_mac, src_mac_next;
  logic [9:0]        consumed, consumed_next;
  logic              tunnel, tunnel_next;
  logic [31:0]       lbl_store [MPLS_MAX];

  logic              done;
  verdict_t          verd;
  logic              lbl_we;
  logic [LBL_IW-1:0] lbl_widx;
  logic [31:0]       lbl_wdata;

  assign advance  = in_q_valid && load_ready;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= (in_valid && !in_stall) || in_stall;
    end
    if (in_valid && !in_stall) begin
      q_first      <= first;
      q_type       <= start_ethertype;
      q_byte_valid <= byte_valid;
      q_byte       <= data_byte;
      q_last       <= last;
    end
  end

  always_comb begin
    logic   active;
    logic   eval_req;
    eval_t  ev;
    logic [15:0] proto;
    phase_next      = phase;
    cur_type_next   = cur_type;
    idx_next        = idx;
    shift_word_next = shift_word;
    pppoe_vc_next   = pppoe_vc;
    vlan_next       = vlan;
    lbl_cnt_next    = lbl_cnt;
    dst_mac_next    = dst_mac;
    src_mac_next    = src_mac;
    consumed_next   = consumed;
    tunnel_next     = tunnel;
    done      = 1'b0;
    verd      = VERD_UNKNOWN;
    lbl_we    = 1'b0;
    lbl_widx  = lbl_cnt[LBL_IW-1:0];
    lbl_wdata = shift_word[31:0];
    eval_req  = 1'b0;
    ev        = '0;
    proto     = '0;
    active    = q_first || (phase != PH_IDLE);

    if (q_first) begin
      cur_type_next   = q_type;
      pppoe_vc_next   = '0;
      vlan_next       = '0;
      lbl_cnt_next    = '0;
      dst_mac_next    = '0;
      src_mac_next    = '0;
      consumed_next   = '0;
      tunnel_next     = 1'b0;
      ev              = evaluate(q_type);
      idx_next        = '0;
      shift_word_next = '0;
      phase_next      = ev.done ? PH_WAIT : ev.phase;
      done            = ev.done;
      verd            = ev.verdict;
    end

    if (active && !done && q_byte_valid) begin
      if (phase_next == PH_PEEK) begin
        // next-header byte is looked at, not consumed
        if (q_byte[7:4] == NIB_IPV4) begin
          cur_type_next = ET_IPV4;
          eval_req      = 1'b1;
        end else if (q_byte[7:4] == NIB_IPV6) begin
          cur_type_next = ET_IPV6;
          eval_req      = 1'b1;
        end else begin
          done = 1'b1;
          verd = VERD_UNKNOWN;
        end
      end else begin
        if (consumed_next != HDR_BYTES_MAX) begin
          consumed_next = consumed_next + 10'd1;
        end
        shift_word_next = {shift_word_next[39:0], q_byte};
        idx_next        = idx_next + 4'd1;
        case (phase_next)
          PH_VLAN: begin
            if (idx_next == VLAN_HDR_LEN) begin
              vlan_next     = shift_word_next[27:16];
              cur_type_next = shift_word_next[15:0];
              eval_req      = 1'b1;
            end
          end
          PH_MPLS: begin
            if (idx_next == MPLS_LBL_LEN) begin
              lbl_wdata = shift_word_next[31:0];
              if (lbl_cnt_next < LBL_CW'(MPLS_MAX)) begin
                lbl_we       = 1'b1;
                lbl_widx     = lbl_cnt_next[LBL_IW-1:0];
                lbl_cnt_next = lbl_cnt_next + LBL_CW'(1);
              end
              idx_next        = '0;
              shift_word_next = '0;
              if (lbl_wdata[MPLS_BOS_BIT]) begin
                phase_next = PH_PEEK;
              end
            end
          end
          PH_GRE: begin
            if (idx_next == GRE_DST_END) begin
              dst_mac_next = shift_word_next;
              tunnel_next  = 1'b1;
            end else if (idx_next == GRE_SRC_END) begin
              src_mac_next = shift_word_next;
            end else if (idx_next == GRE_HDR_LEN) begin
              cur_type_next = shift_word_next[15:0];
              eval_req      = 1'b1;
            end
          end
          PH_PPPOE: begin
            if (idx_next == PPPOE_VC_END) begin
              pppoe_vc_next = shift_word_next[15:0];
            end else if (idx_next == PPPOE_HDR_LEN) begin
              proto = shift_word_next[15:0];
              if (pppoe_vc_next[15:8] != PPPOE_VER_TYPE ||
                  pppoe_vc_next[7:0] != PPPOE_CODE_SESSION ||
                  (proto != PPP_IPV4 && proto != PPP_IPV6)) begin
                done = 1'b1;
                verd = VERD_UNKNOWN;
              end else begin
                cur_type_next = (proto == PPP_IPV4) ? ET_IPV4 : ET_IPV6;
                eval_req      = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (eval_req) begin
        ev              = evaluate(cur_type_next);
        idx_next        = '0;
        shift_word_next = '0;
        if (!ev.done) begin
          phase_next = ev.phase;
          if (ev.phase == PH_MPLS) begin
            lbl_cnt_next = '0;
          end
        end
        done = ev.done;
        verd = ev.verdict;
      end
    end

    // packet ran out before a verdict
    if (active && !done && q_last) begin
      done = 1'b1;
      verd = VERD_LEN_ERR;
    end

    if (done) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      lbl_cnt <= '0;
    end else if (advance) begin
      phase   <= phase_next;
      lbl_cnt <= lbl_cnt_next;
    end
    if (advance) begin
      cur_type   <= cur_type_next;
      idx        <= idx_next;
      shift_word <= shift_word_next;
      pppoe_vc   <= pppoe_vc_next;
      vlan       <= vlan_next;
      dst_mac    <= dst_mac_next;
      src_mac    <= src_mac_next;
      consumed   <= consumed_next;
      tunnel     <= tunnel_next;
      if (lbl_we) begin
        lbl_store[lbl_widx] <= lbl_wdata;
      end
    end
  end

  assign lbl_rd_data = lbl_store[lbl_rd_idx];

  assign run_load               = advance && done;
  assign run_info.verdict       = verd;
  assign run_info.next_protocol = cur_type_next;
  assign run_info.vlan_id       = vlan_next;
  assign run_info.label_count   = lbl_cnt_next;
  assign run_info.dst_mac       = dst_mac_next;
  assign run_info.src_mac       = src_mac_next;
  assign run_info.tunnel_seen   = tunnel_next;
  assign run_info.header_bytes  = consumed_next;

  a_lbl_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    lbl_cnt <= LBL_CW'(MPLS_MAX))
    else $error("label count above limit");

  a_peek_has_label: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PEEK |-> lbl_cnt != '0)
    else $error("peek phase without a stored label");

  a_wait_transient: assert property (@(posedge clk) disable iff (rst)
    phase != PH_WAIT)
    else $error("parse left in wait phase");

endmodule

// ----- hdl/l2ep_emitter.sv -----
// Result register and run sequencer: verdict result, then one result per label.
// Depends on l2ep_pkg; reads the label store held in l2ep_parser.
module l2ep_emitter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        run_load,
  input  l2ep_pkg::run_info_t         run_info,
  output logic                        load_ready,
  output logic [l2ep_pkg::LBL_IW-1:0] lbl_rd_idx,
  input  logic [31:0]                 lbl_rd_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  verdict,
  output logic [15:0]                 next_protocol,
  output logic [11:0]                 vlan_id,
  output logic [3:0]                  mpls_count,
  output logic [31:0]                 mpls_label,
  output logic [47:0]                 dst_mac,
  output logic [47:0]                 src_mac,
  output logic                        tunnel_seen,
  output logic [9:0]                  header_bytes,
  output logic                        last_result
);
  import l2ep_pkg::*;

  run_info_t         info;
  logic [LBL_CW-1:0] k;       // labels already shown in this run
  logic [LBL_CW-1:0] k_inc;
  logic              out_take;

  assign out_take   = out_valid && !out_stall;
  assign load_ready = !out_valid || (out_take && last_result);
  assign k_inc      = k + LBL_CW'(1);
  assign lbl_rd_idx = k[LBL_IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run_load) begin
      out_valid <= 1'b1;
    end else if (out_take && last_result) begin
      out_valid <= 1'b0;
    end
    if (run_load) begin
      info        <= run_info;
      k           <= '0;
      mpls_label  <= '0;
      last_result <= (run_info.label_count == '0);
    end else if (out_take && !last_result) begin
      mpls_label  <= lbl_rd_data;
      k           <= k_inc;
      last_result <= (k_inc == info.label_count);
    end
  end

  assign verdict       = info.verdict;
  assign next_protocol = info.next_protocol;
  assign vlan_id       = info.vlan_id;
  assign mpls_count    = 4'(info.label_count);
  assign dst_mac       = info.dst_mac;
  assign src_mac       = info.src_mac;
  assign tunnel_seen   = info.tunnel_seen;
  assign header_bytes  = info.header_bytes;

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> k <= info.label_count)
    else $error("label index past run length");

  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_result == (k == info.label_count)))
    else $error("last_result out of step with label index");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_take && !last_result |=> out_valid && k == $past(k_inc))
    else $error("run ended early");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    run_load |-> load_ready)
    else $error("new run loaded over a run in progress");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for l2_encapsulation_parser_top: directed header cases, then random
// packet chains with idling, back-pressure and truncation. Depends on l2ep_pkg and the block.
`timescale 1ns / 100ps

module tb_top;
  import l2ep_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 10;

  // ethertypes that the block has no header walk for
  localparam logic [15:0] ET_ARP        = 16'h0806;
  localparam logic [15:0] ET_LLDP       = 16'h88CC;
  localparam logic [15:0] ET_FLOW_CTRL  = 16'h8808;
  localparam logic [15:0] ET_LOOPBACK   = 16'h9000;
  localparam logic [15:0] ET_PPPOE_DISC = 16'h8863;

  typedef struct {
    verdict_t    verdict;
    logic [15:0] next_protocol;
    logic [11:0] vlan_id;
    logic [3:0]  mpls_count;
    logic [31:0] mpls_label;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic        tunnel_seen;
    logic [9:0]  header_bytes;
    logic        last_result;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        first = 1'b0;
  logic [15:0] start_ethertype = '0;
  logic        byte_valid = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  verdict;
  logic [15:0] next_protocol;
  logic [11:0] vlan_id;
  logic [3:0]  mpls_count;
  logic [31:0] mpls_label;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic        tunnel_seen;
  logic [9:0]  header_bytes;
  logic        last_result;

  l2_encapsulation_parser_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .first(first), .start_ethertype(start_ethertype), .byte_valid(byte_valid),
    .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .verdict(verdict), .next_protocol(next_protocol), .vlan_id(vlan_id),
    .mpls_count(mpls_count), .mpls_label(mpls_label), .dst_mac(dst_mac), .src_mac(src_mac),
    .tunnel_seen(tunnel_seen), .header_bytes(header_bytes), .last_result(last_result)
  );

  always #2 clk = ~clk;

  parse_result_t pending_results[$];
  parse_result_t want;
  logic [7:0]    pkt_bytes[$];
  int            err_cnt = 0;
  int            cycles = 0;
  int            items_live = 0;
  int            hold_cycles = 0;
  bit            idle_on = 1'b1;

  // parser state mirror
  phase_t      prs_phase = PH_IDLE;
  logic [15:0] prs_type = '0;
  logic [3:0]  prs_idx = '0;
  logic [47:0] prs_shift = '0;
  logic [15:0] prs_pppoe_vc = '0;
  logic [11:0] prs_vlan = '0;
  logic [31:0] prs_labels[MPLS_MAX];
  int          prs_nlabels = 0;
  logic [47:0] prs_dmac = '0;
  logic [47:0] prs_smac = '0;
  logic [9:0]  prs_bytes = '0;
  logic        prs_tunnel = 1'b0;

  initial foreach (prs_labels[i]) prs_labels[i] = '0;

  // ---------------------------------------------------------------- predictor

  function automatic bit eval_type(output verdict_t v);
    prs_idx = '0;
    prs_shift = '0;
    v = VERD_UNKNOWN;
    if (prs_type <= ET_MAX_LEN) return 1'b1;
    if (prs_type == ET_IPV4 || prs_type == ET_IPV6) begin
      v = VERD_IP;
      return 1'b1;
    end
    if (prs_type == ET_VLAN || prs_type == ET_QINQ) begin
      prs_phase = PH_VLAN;
      return 1'b0;
    end
    if (prs_type == ET_MPLS) begin
      prs_nlabels = 0;
      prs_phase = PH_MPLS;
      return 1'b0;
    end
    if (prs_type == ET_TEB) begin
      prs_phase = PH_GRE;
      return 1'b0;
    end
    if (prs_type == ET_PPPOE) begin
      prs_phase = PH_PPPOE;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit consume_byte(input logic [7:0] b, output verdict_t v);
    logic [31:0] lab;
    logic [15:0] proto;
    v = VERD_UNKNOWN;
    // byte after bottom of stack is only looked at, not counted
    if (prs_phase == PH_PEEK) begin
      if (b[7:4] == NIB_IPV4) prs_type = ET_IPV4;
      else if (b[7:4] == NIB_IPV6) prs_type = ET_IPV6;
      else return 1'b1;
      return eval_type(v);
    end
    if (prs_bytes < HDR_BYTES_MAX) prs_bytes = prs_bytes + 10'd1;
    prs_shift = {prs_shift[39:0], b};
    prs_idx = prs_idx + 4'd1;
    case (prs_phase)
      PH_VLAN: begin
        if (prs_idx == VLAN_HDR_LEN) begin
          prs_vlan = prs_shift[27:16];
          prs_type = prs_shift[15:0];
          return eval_type(v);
        end
      end
      PH_MPLS: begin
        if (prs_idx == MPLS_LBL_LEN) begin
          lab = prs_shift[31:0];
          if (prs_nlabels < MPLS_MAX) begin
            prs_labels[prs_nlabels] = lab;
            prs_nlabels++;
          end
          prs_idx = '0;
          prs_shift = '0;
          if (lab[MPLS_BOS_BIT]) prs_phase = PH_PEEK;
        end
      end
      PH_GRE: begin
        if (prs_idx == GRE_DST_END) begin
          prs_dmac = prs_shift;
          prs_tunnel = 1'b1;
        end else if (prs_idx == GRE_SRC_END) begin
          prs_smac = prs_shift;
        end else if (prs_idx == GRE_HDR_LEN) begin
          prs_type = prs_shift[15:0];
          return eval_type(v);
        end
      end
      PH_PPPOE: begin
        if (prs_idx == PPPOE_VC_END) begin
          prs_pppoe_vc = prs_shift[15:0];
        end else if (prs_idx == PPPOE_HDR_LEN) begin
          proto = prs_shift[15:0];
          if (prs_pppoe_vc[15:8] != PPPOE_VER_TYPE) return 1'b1;
          if (prs_pppoe_vc[7:0] != PPPOE_CODE_SESSION) return 1'b1;
          if (proto != PPP_IPV4 && proto != PPP_IPV6) return 1'b1;
          prs_type = (proto == PPP_IPV4) ? ET_IPV4 : ET_IPV6;
          return eval_type(v);
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic emit_run(input verdict_t v);
    parse_result_t r;
    for (int k = 0; k <= prs_nlabels; k++) begin
      r.verdict       = v;
      r.next_protocol = prs_type;
      r.vlan_id       = prs_vlan;
      r.mpls_count    = prs_nlabels[3:0];
      r.mpls_label    = (k == 0) ? 32'd0 : prs_labels[k-1];
      r.dst_mac       = prs_dmac;
      r.src_mac       = prs_smac;
      r.tunnel_seen   = prs_tunnel;
      r.header_bytes  = prs_bytes;
      r.last_result   = (k == prs_nlabels);
      pending_results.push_back(r);
    end
    prs_phase = PH_IDLE;
  endtask

  task automatic parse_item(input bit f, input logic [15:0] et, input bit bv,
                            input logic [7:0] b, input bit lst);
    verdict_t v;
    if (f) begin
      prs_type = et;
      prs_idx = '0;
      prs_shift = '0;
      prs_pppoe_vc = '0;
      prs_vlan = '0;
      prs_nlabels = 0;
      prs_dmac = '0;
      prs_smac = '0;
      prs_bytes = '0;
      prs_tunnel = 1'b0;
      prs_phase = PH_WAIT;
      if (eval_type(v)) begin
        emit_run(v);
        return;
      end
    end else if (prs_phase == PH_IDLE) begin
      return;
    end
    if (bv && consume_byte(b, v)) begin
      emit_run(v);
      return;
    end
    if (lst) emit_run(VERD_LEN_ERR);
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else out_stall <= idle_on && ($urandom_range(99) < 10);
  end

  function automatic void check_field(input string fname, input logic [63:0] exp_val,
                                      input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      err_cnt++;
      if (err_cnt <= SHOW_LIMIT)
        $display("mismatch on %s: expected %h, got %h", fname, exp_val, got_val);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOW_LIMIT)
          $display("result transaction with nothing expected: verdict %h proto %h",
                   verdict, next_protocol);
      end else begin
        want = pending_results.pop_front();
        check_field("verdict", 64'(want.verdict), 64'(verdict));
        check_field("next_protocol", 64'(want.next_protocol), 64'(next_protocol));
        check_field("vlan_id", 64'(want.vlan_id), 64'(vlan_id));
        check_field("mpls_count", 64'(want.mpls_count), 64'(mpls_count));
        check_field("mpls_label", 64'(want.mpls_label), 64'(mpls_label));
        check_field("dst_mac", 64'(want.dst_mac), 64'(dst_mac));
        check_field("src_mac", 64'(want.src_mac), 64'(src_mac));
        check_field("tunnel_seen", 64'(want.tunnel_seen), 64'(tunnel_seen));
        check_field("header_bytes", 64'(want.header_bytes), 64'(header_bytes));
        check_field("last_result", 64'(want.last_result), 64'(last_result));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_item(input bit f, input logic [15:0] et, input bit bv,
                           input logic [7:0] b, input bit lst);
    while (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    first           <= f;
    start_ethertype <= et;
    byte_valid      <= bv;
    data_byte       <= b;
    last            <= lst;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (f || prs_phase != PH_IDLE) items_live++;
    parse_item(f, et, bv, b, lst);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push16(input logic [15:0] w);
    pkt_bytes.push_back(w[15:8]);
    pkt_bytes.push_back(w[7:0]);
  endtask

  function automatic logic [15:0] pick_type(input int depth);
    int r;
    int k;
    r = $urandom_range(99);
    if (depth >= 3) r = (r < 60) ? 0 : 90;
    if (r < 25) return $urandom_range(1) ? ET_IPV4 : ET_IPV6;
    if (r < 45) return $urandom_range(1) ? ET_VLAN : ET_QINQ;
    if (r < 58) return ET_MPLS;
    if (r < 70) return ET_TEB;
    if (r < 84) return ET_PPPOE;
    k = $urandom_range(7);
    case (k)
      0: return ET_ARP;
      1: return ET_LLDP;
      2: return ET_FLOW_CTRL;
      3: return ET_LOOPBACK;
      4: return ET_PPPOE_DISC;
      5: return 16'($urandom_range(ET_MAX_LEN));
      6: return ET_MAX_LEN + 16'd1;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // appends the header belonging to et and everything it leads to
  task automatic build_chain(input logic [15:0] et, input int depth);
    logic [15:0] nxt;
    logic [31:0] lab;
    int          nlab;
    int          r;
    if (et == ET_VLAN || et == ET_QINQ) begin
      nxt = pick_type(depth + 1);
      push16(16'($urandom_range(65535)));
      push16(nxt);
      build_chain(nxt, depth + 1);
      return;
    end
    if (et == ET_MPLS) begin
      nlab = ($urandom_range(99) < 15) ? $urandom_range(MPLS_MAX + 3, MPLS_MAX - 1)
                                       : $urandom_range(3, 1);
      for (int i = 0; i < nlab; i++) begin
        lab = $urandom;
        lab[MPLS_BOS_BIT] = (i == nlab - 1);
        push16(lab[31:16]);
        push16(lab[15:0]);
      end
      r = $urandom_range(9);
      pkt_bytes.push_back({(r < 4) ? NIB_IPV4 : (r < 8) ? NIB_IPV6 : 4'($urandom),
                           4'($urandom)});
    end else if (et == ET_TEB) begin
      repeat (12) pkt_bytes.push_back(8'($urandom_range(255)));
      nxt = pick_type(depth + 1);
      push16(nxt);
      build_chain(nxt, depth + 1);
      return;
    end else if (et == ET_PPPOE) begin
      pkt_bytes.push_back(($urandom_range(99) < 85) ? PPPOE_VER_TYPE : 8'($urandom));
      pkt_bytes.push_back(($urandom_range(99) < 85) ? PPPOE_CODE_SESSION : 8'($urandom));
      push16(16'($urandom_range(65535)));
      push16(16'($urandom_range(65535)));
      r = $urandom_range(99);
      push16((r < 40) ? PPP_IPV4 : (r < 80) ? PPP_IPV6 : 16'($urandom));
    end
    // payload after the verdict point, ignored by the block
    repeat ($urandom_range(3)) pkt_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic new_packet(input logic [15:0] start_et);
    pkt_bytes.delete();
    build_chain(start_et, 0);
  endtask

  // with faults: early end, missing last (next first restarts) and empty items
  task automatic send_packet(input logic [15:0] start_et, input bit faults);
    int         n;
    int         idx;
    bit         is_first;
    bit         use_b;
    bit         fin;
    bit         abort;
    logic [7:0] b;
    abort = faults && ($urandom_range(19) == 0);
    if (faults && $urandom_range(99) < 12) begin
      n = $urandom_range(pkt_bytes.size());
      while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
    end
    n = pkt_bytes.size();
    idx = 0;
    is_first = 1'b1;
    do begin
      if (!is_first && faults && $urandom_range(19) == 0)
        send_item(1'b0, 16'($urandom_range(65535)), 1'b0, 8'($urandom_range(255)), 1'b0);
      use_b = (idx < n) && (!is_first || $urandom_range(9) < 8);
      b = use_b ? pkt_bytes[idx] : 8'($urandom);
      if (use_b) idx++;
      fin = (idx >= n) && !abort;
      send_item(is_first, is_first ? start_et : 16'($urandom), use_b, b, fin);
      is_first = 1'b0;
    end while (idx < n);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 1))
      send_item($urandom_range(9) == 0, 16'($urandom_range(65535)),
                1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_edges();
    // verdict straight from the starting ethertype; the byte on that item is dropped
    send_item(1'b1, ET_IPV4, 1'b1, 8'hFF, 1'b0);
    send_item(1'b1, ET_MAX_LEN, 1'b1, 8'h00, 1'b0);
    send_item(1'b1, ET_MAX_LEN + 16'd1, 1'b0, 8'hFF, 1'b0);
    send_item(1'b1, 16'hFFFF, 1'b1, 8'hA5, 1'b1);  // verdict and last together
    send_item(1'b1, 16'h0000, 1'b0, 8'h00, 1'b0);
    // after a verdict, items without first are absorbed
    send_item(1'b0, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
    send_item(1'b0, 16'h0000, 1'b0, 8'h00, 1'b0);
    // VLAN cut short with nothing consumed
    send_item(1'b1, ET_VLAN, 1'b0, 8'h00, 1'b1);
    // one MPLS label with an empty item in the middle, peek gives IPv4
    send_item(1'b1, ET_MPLS, 1'b1, 8'h00, 1'b0);
    send_item(1'b0, 16'h0000, 1'b0, 8'hFF, 1'b0);
    send_item(1'b0, 16'h0000, 1'b1, 8'h00, 1'b0);
    send_item(1'b0, 16'h0000, 1'b1, 8'h01, 1'b0);
    send_item(1'b0, 16'h0000, 1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 16'h0000, 1'b1, 8'h45, 1'b1);
    // all-ones label, peek nibble neither 4 nor 6
    send_item(1'b1, ET_MPLS, 1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 16'hFFFF, 1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 16'hFFFF, 1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 16'hFFFF, 1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 16'hFFFF, 1'b1, 8'h00, 1'b0);
    drain_results();
  endtask

  // a long tag stack drives the consumed count into saturation
  task automatic test_header_saturation();
    pkt_bytes.delete();
    for (int i = 0; i < 260; i++) begin
      push16(16'($urandom_range(65535)));
      push16((i == 259) ? ET_IPV6 : (i % 2) ? ET_QINQ : ET_VLAN);
    end
    send_packet(ET_VLAN, 1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int target);
    int          base;
    logic [15:0] st;
    base = items_live;
    while (items_live - base < target) begin
      if ($urandom_range(99) < 12) send_noise();
      else begin
        st = pick_type(0);
        new_packet(st);
        send_packet(st, 1'b1);
      end
    end
  endtask

  task automatic test_no_idle_burst();
    idle_on = 1'b0;
    test_random_traffic(70);
    idle_on = 1'b1;
  endtask

  // long receiver hold-off while MPLS runs keep coming, so the input backs up
  task automatic test_output_backpressure();
    hold_cycles = 400;
    repeat (6) begin
      new_packet(ET_MPLS);
      send_packet(ET_MPLS, 1'b0);
    end
  endtask

  task automatic test_sender_pause();
    test_random_traffic(20);
    drain_results();
    test_random_traffic(20);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_header_saturation();
    test_random_traffic(120);
    test_no_idle_burst();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic(100);
    drain_results();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
